@@ design/tile_window_residency_map_core_macros.svh @@
// assertion macros shared by the residency map core
`ifndef TILE_WINDOW_RESIDENCY_MAP_CORE_MACROS_SVH
`define TILE_WINDOW_RESIDENCY_MAP_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define TWR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TWR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/twr_pkg.sv @@
// shared constants, payload types and control types of the residency map core
`timescale 1ns / 1ps

package twr_pkg;

    // window geometry
    localparam int G_SIDE  = 16;
    localparam int G_BITS  = $clog2(G_SIDE);
    localparam int CELLS   = G_SIDE * G_SIDE;
    localparam int ADDR_W  = 2 * G_BITS;
    localparam int POS_W   = G_BITS + 2;
    localparam int COORD_W = 32;

    // load rate register
    localparam int RATE_W = 6;
    localparam logic [RATE_W-1:0] RATE_CAP   = RATE_W'(32);
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(4);

    // derived constants
    localparam logic [COORD_W-1:0] HALF_SIDE = COORD_W'(G_SIDE / 2);
    localparam logic [COORD_W-1:0] LOW_RESET = COORD_W'(-(G_SIDE / 2));
    localparam logic [ADDR_W-1:0]  CENTRE_IDX =
        ADDR_W'((G_SIDE / 2) * G_SIDE + (G_SIDE / 2));
    localparam logic [ADDR_W-1:0]  LAST_IDX = ADDR_W'(CELLS - 1);
    localparam logic [G_BITS-1:0]  LEN_MAX  = G_BITS'(G_SIDE - 1);
    localparam logic signed [POS_W-1:0] POS_SIDE    = POS_W'(G_SIDE);
    localparam logic signed [POS_W-1:0] SP_START_X  = POS_W'(G_SIDE / 2 - 1);
    localparam logic signed [POS_W-1:0] SP_START_Z  = POS_W'(G_SIDE / 2);

    // input item
    typedef struct packed {
        logic signed [COORD_W-1:0] player_tile_x;
        logic signed [COORD_W-1:0] player_tile_z;
    } t_twr_in;

    // result item
    typedef struct packed {
        logic                      is_creation;
        logic signed [COORD_W-1:0] tile_x;
        logic signed [COORD_W-1:0] tile_z;
        logic                      last;
    } t_twr_out;

    // controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SP_READ,
        ST_SP_TEST,
        ST_SH_INIT,
        ST_SHIFT,
        ST_SH_DRAIN,
        ST_CT_READ,
        ST_CT_TEST,
        ST_SUMMARY
    } t_twr_state;

    // bitmap read address source
    typedef enum logic [1:0] {
        RD_SPIRAL,
        RD_SHIFT,
        RD_CENTRE
    } t_twr_rd_sel;

    // result item source
    typedef enum logic [1:0] {
        OUT_SPIRAL,
        OUT_CENTRE,
        OUT_SUMMARY
    } t_twr_out_sel;

    // commands from controller to datapath
    typedef struct packed {
        logic         clr_step;
        logic         capture;
        logic         sp_advance;
        logic         sp_mark;
        logic         sh_init;
        logic         sh_step;
        logic         sh_commit;
        logic         ct_mark;
        logic         out_load;
        t_twr_out_sel out_sel;
        t_twr_rd_sel  rd_sel;
    } t_twr_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic cnt_last;
        logic left_zero;
        logic left_one;
        logic sp_inside;
        logic sp_end;
        logic rd_bit;
        logic out_free;
    } t_twr_sts;

endpackage

@@ design/twr_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps

module twr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/twr_ctrl.sv @@
// controller state machine of the residency map core
`timescale 1ns / 1ps

module twr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  twr_pkg::t_twr_sts i_sts,
    output twr_pkg::t_twr_cmd o_cmd
);

    import twr_pkg::*;

    t_twr_state r_state;
    t_twr_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.rd_sel  = RD_SPIRAL;
        o_cmd.out_sel = OUT_SPIRAL;
        o_in_ready    = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                // zero the bitmap one entry a cycle
                o_cmd.clr_step = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_SP_READ;
                end
            end
            ST_SP_READ: begin
                // first spiral cell read issued here
                if (i_sts.left_zero) begin
                    n_state = ST_SH_INIT;
                end else begin
                    n_state = ST_SP_TEST;
                end
            end
            ST_SP_TEST: begin
                if (i_sts.sp_inside && !i_sts.rd_bit) begin
                    // missing tile: mark and emit once the output is free
                    if (i_sts.out_free) begin
                        o_cmd.sp_mark  = 1'b1;
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_sel  = OUT_SPIRAL;
                        if (i_sts.left_one || i_sts.sp_end) begin
                            n_state = ST_SH_INIT;
                        end else begin
                            o_cmd.sp_advance = 1'b1;
                        end
                    end
                end else if (i_sts.sp_end) begin
                    n_state = ST_SH_INIT;
                end else begin
                    o_cmd.sp_advance = 1'b1;
                end
            end
            ST_SH_INIT: begin
                o_cmd.sh_init = 1'b1;
                n_state       = ST_SHIFT;
            end
            ST_SHIFT: begin
                o_cmd.rd_sel  = RD_SHIFT;
                o_cmd.sh_step = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = ST_SH_DRAIN;
                end
            end
            ST_SH_DRAIN: begin
                // last shifted entry is written as the banks swap
                o_cmd.sh_commit = 1'b1;
                n_state         = ST_CT_READ;
            end
            ST_CT_READ: begin
                o_cmd.rd_sel = RD_CENTRE;
                n_state      = ST_CT_TEST;
            end
            ST_CT_TEST: begin
                o_cmd.rd_sel = RD_CENTRE;
                if (!i_sts.rd_bit) begin
                    if (i_sts.out_free) begin
                        o_cmd.ct_mark  = 1'b1;
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_sel  = OUT_CENTRE;
                        n_state        = ST_SUMMARY;
                    end
                end else begin
                    n_state = ST_SUMMARY;
                end
            end
            ST_SUMMARY: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_SUMMARY;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/twr_dp.sv @@
// datapath of the residency map core: bitmap banks, spiral walker, shifter, output register
`timescale 1ns / 1ps

module twr_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  twr_pkg::t_twr_cmd            i_cmd,
    output twr_pkg::t_twr_sts            o_sts,
    input  twr_pkg::t_twr_in             i_in_data,
    input  logic                         i_cfg_we,
    input  logic [twr_pkg::RATE_W-1:0]   i_cfg_data,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output twr_pkg::t_twr_out            o_out_data
);

    import twr_pkg::*;

    // configuration and tick registers
    logic [RATE_W-1:0]  r_rate;
    logic [RATE_W-1:0]  r_left;
    logic [COORD_W-1:0] r_px;
    logic [COORD_W-1:0] r_pz;
    logic [COORD_W-1:0] r_low_x;
    logic [COORD_W-1:0] r_low_z;

    // spiral walker
    logic signed [POS_W-1:0] r_pos_x;
    logic signed [POS_W-1:0] r_pos_z;
    logic signed [POS_W-1:0] n_pos_x;
    logic signed [POS_W-1:0] n_pos_z;
    logic signed [POS_W-1:0] w_step;
    logic                    r_axis_z;
    logic                    n_axis_z;
    logic                    r_dir_neg;
    logic                    n_dir_neg;
    logic                    r_final;
    logic                    n_final;
    logic [G_BITS-1:0]       r_len;
    logic [G_BITS-1:0]       n_len;
    logic [G_BITS-1:0]       r_cnt;
    logic [G_BITS-1:0]       n_cnt;
    logic                    w_leg_end;
    logic                    w_sp_inside;
    logic [ADDR_W-1:0]       w_cur_idx;
    logic [ADDR_W-1:0]       w_next_idx;

    // shifter
    logic               r_bank;
    logic [ADDR_W-1:0]  r_dst;
    logic [COORD_W-1:0] r_off_x;
    logic [COORD_W-1:0] r_off_z;
    logic               r_sh_valid;
    logic [ADDR_W-1:0]  r_sh_waddr;
    logic               r_sh_inside;
    logic [COORD_W-1:0] w_nlx;
    logic [COORD_W-1:0] w_nlz;
    logic [COORD_W-1:0] w_src_x;
    logic [COORD_W-1:0] w_src_z;
    logic               w_src_inside;
    logic [ADDR_W-1:0]  w_src_idx;

    // bitmap ports
    logic [ADDR_W-1:0] w_raddr;
    logic [0:0]        w_rdata0;
    logic [0:0]        w_rdata1;
    logic              w_rd_bit;
    logic              w_act_we;
    logic [ADDR_W-1:0] w_act_addr;
    logic              w_act_data;
    logic              w_we0;
    logic              w_we1;
    logic [ADDR_W-1:0] w_waddr0;
    logic [ADDR_W-1:0] w_waddr1;
    logic [0:0]        w_wdata0;
    logic [0:0]        w_wdata1;
    logic [0:0]        w_sh_wdata;

    // output register
    logic     r_out_valid;
    t_twr_out r_out;
    t_twr_out n_out;
    logic     w_out_free;

    // load rate register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
        end else if (i_cfg_we) begin
            r_rate <= i_cfg_data;
        end
    end

    // player capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_px <= i_in_data.player_tile_x;
            r_pz <= i_in_data.player_tile_z;
        end
    end

    // budget of spiral marks left this tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_cmd.capture) begin
            r_left <= (r_rate > RATE_CAP) ? RATE_CAP : r_rate;
        end else if (i_cmd.sp_mark) begin
            r_left <= r_left - RATE_W'(1);
        end
    end

    // spiral step: legs of growing length, direction reversing every leg pair
    assign w_leg_end = (r_cnt == r_len - G_BITS'(1));
    assign w_step    = r_dir_neg ? {POS_W{1'b1}} : POS_W'(1);

    always_comb begin
        n_pos_x   = r_pos_x;
        n_pos_z   = r_pos_z;
        n_axis_z  = r_axis_z;
        n_dir_neg = r_dir_neg;
        n_final   = r_final;
        n_len     = r_len;
        n_cnt     = r_cnt + G_BITS'(1);
        if (!w_leg_end) begin
            if (r_axis_z) begin
                n_pos_z = r_pos_z + w_step;
            end else begin
                n_pos_x = r_pos_x + w_step;
            end
        end else if (!r_axis_z) begin
            // x leg done, z leg of the same length follows
            n_axis_z = 1'b1;
            n_cnt    = '0;
            n_pos_z  = r_pos_z + w_step;
        end else begin
            // z leg done, turn round and lengthen, or start the closing x leg
            n_axis_z  = 1'b0;
            n_cnt     = '0;
            n_dir_neg = !r_dir_neg;
            n_pos_x   = r_pos_x - w_step;
            if (r_len == LEN_MAX) begin
                n_final = 1'b1;
            end else begin
                n_len = r_len + G_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= SP_START_X;
            r_pos_z   <= SP_START_Z;
            r_axis_z  <= 1'b0;
            r_dir_neg <= 1'b1;
            r_final   <= 1'b0;
            r_len     <= G_BITS'(1);
            r_cnt     <= '0;
        end else if (i_cmd.capture) begin
            r_pos_x   <= SP_START_X;
            r_pos_z   <= SP_START_Z;
            r_axis_z  <= 1'b0;
            r_dir_neg <= 1'b1;
            r_final   <= 1'b0;
            r_len     <= G_BITS'(1);
            r_cnt     <= '0;
        end else if (i_cmd.sp_advance) begin
            r_pos_x   <= n_pos_x;
            r_pos_z   <= n_pos_z;
            r_axis_z  <= n_axis_z;
            r_dir_neg <= n_dir_neg;
            r_final   <= n_final;
            r_len     <= n_len;
            r_cnt     <= n_cnt;
        end
    end

    assign w_sp_inside = !r_pos_x[POS_W-1] && (r_pos_x < POS_SIDE)
                      && !r_pos_z[POS_W-1] && (r_pos_z < POS_SIDE);
    assign w_cur_idx   = {r_pos_z[G_BITS-1:0], r_pos_x[G_BITS-1:0]};
    assign w_next_idx  = {n_pos_z[G_BITS-1:0], n_pos_x[G_BITS-1:0]};

    // shift source for the destination entry under the sweep counter
    assign w_nlx        = r_px - HALF_SIDE;
    assign w_nlz        = r_pz - HALF_SIDE;
    assign w_src_x      = r_off_x + COORD_W'(r_dst[G_BITS-1:0]);
    assign w_src_z      = r_off_z + COORD_W'(r_dst[ADDR_W-1:G_BITS]);
    assign w_src_inside = (w_src_x[COORD_W-1:G_BITS] == '0)
                       && (w_src_z[COORD_W-1:G_BITS] == '0);
    assign w_src_idx    = {w_src_z[G_BITS-1:0], w_src_x[G_BITS-1:0]};

    // offsets, sweep counter, bank and window low corner
    always_ff @(posedge i_clk) begin
        if (i_cmd.sh_init) begin
            r_off_x <= w_nlx - r_low_x;
            r_off_z <= w_nlz - r_low_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dst      <= '0;
            r_sh_valid <= 1'b0;
            r_bank     <= 1'b0;
            r_low_x    <= LOW_RESET;
            r_low_z    <= LOW_RESET;
        end else begin
            r_sh_valid <= i_cmd.sh_step;
            if (i_cmd.sh_init) begin
                r_dst <= '0;
            end else if (i_cmd.sh_step || i_cmd.clr_step) begin
                r_dst <= r_dst + ADDR_W'(1);
            end
            if (i_cmd.sh_commit) begin
                r_bank  <= !r_bank;
                r_low_x <= w_nlx;
                r_low_z <= w_nlz;
            end
        end
    end

    // shift write stage, in the cycle after its read
    always_ff @(posedge i_clk) begin
        if (i_cmd.sh_step) begin
            r_sh_waddr  <= r_dst;
            r_sh_inside <= w_src_inside;
        end
    end

    // read address selection
    always_comb begin
        case (i_cmd.rd_sel)
            RD_SPIRAL: w_raddr = i_cmd.sp_advance ? w_next_idx : w_cur_idx;
            RD_SHIFT:  w_raddr = w_src_idx;
            RD_CENTRE: w_raddr = CENTRE_IDX;
            default:   w_raddr = w_cur_idx;
        endcase
    end

    assign w_rd_bit = r_bank ? w_rdata1[0] : w_rdata0[0];

    // active bank takes clears and marks, the other bank takes the shifted map
    assign w_act_we   = i_cmd.clr_step || i_cmd.sp_mark || i_cmd.ct_mark;
    assign w_act_addr = i_cmd.clr_step ? r_dst : (i_cmd.sp_mark ? w_cur_idx : CENTRE_IDX);
    assign w_act_data = !i_cmd.clr_step;
    assign w_sh_wdata = r_sh_inside && w_rd_bit;

    assign w_we0    = r_bank ? r_sh_valid : w_act_we;
    assign w_we1    = r_bank ? w_act_we : r_sh_valid;
    assign w_waddr0 = r_bank ? r_sh_waddr : w_act_addr;
    assign w_waddr1 = r_bank ? w_act_addr : r_sh_waddr;
    assign w_wdata0 = r_bank ? w_sh_wdata : w_act_data;
    assign w_wdata1 = r_bank ? w_act_data : w_sh_wdata;

    twr_ram #(
        .WIDTH (1),
        .DEPTH (CELLS)
    ) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (w_we0),
        .i_waddr (w_waddr0),
        .i_wdata (w_wdata0),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata0)
    );

    twr_ram #(
        .WIDTH (1),
        .DEPTH (CELLS)
    ) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (w_we1),
        .i_waddr (w_waddr1),
        .i_wdata (w_wdata1),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata1)
    );

    // result item selection
    always_comb begin
        case (i_cmd.out_sel)
            OUT_SPIRAL: begin
                n_out.is_creation = 1'b1;
                n_out.tile_x      = r_low_x + COORD_W'(r_pos_x[G_BITS-1:0]);
                n_out.tile_z      = r_low_z + COORD_W'(r_pos_z[G_BITS-1:0]);
                n_out.last        = 1'b0;
            end
            OUT_CENTRE: begin
                n_out.is_creation = 1'b1;
                n_out.tile_x      = r_px;
                n_out.tile_z      = r_pz;
                n_out.last        = 1'b0;
            end
            OUT_SUMMARY: begin
                n_out.is_creation = 1'b0;
                n_out.tile_x      = r_low_x;
                n_out.tile_z      = r_low_z;
                n_out.last        = 1'b1;
            end
            default: begin
                n_out.is_creation = 1'b0;
                n_out.tile_x      = r_low_x;
                n_out.tile_z      = r_low_z;
                n_out.last        = 1'b1;
            end
        endcase
    end

    // output register
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // status
    assign o_sts.cnt_last  = (r_dst == LAST_IDX);
    assign o_sts.left_zero = (r_left == '0);
    assign o_sts.left_one  = (r_left == RATE_W'(1));
    assign o_sts.sp_inside = w_sp_inside;
    assign o_sts.sp_end    = w_leg_end && !r_axis_z && r_final;
    assign o_sts.rd_bit    = w_rd_bit;
    assign o_sts.out_free  = w_out_free;

endmodule

@@ design/tile_window_residency_map_core.sv @@
// top level of the tile window residency map core
// Usage:
//   Input channel (i_in_valid / o_in_ready, i_in_data) takes one tick item: the player tile.
//   Output channel (o_out_valid / i_out_ready, o_out_data) gives the items of that tick:
//   one creation item per tile newly made resident by the spiral walk (at most load_rate,
//   saturated at 32), then one for the centre tile if it was missing, then a summary item
//   carrying the new window low corner with last set.
//   Configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_data) writes load_rate and is
//   always ready; the user must write it only while no tick is in progress (unenforced).
// Timing:
//   one tick item at a time. The spiral walk tests one cell per cycle unless it waits on
//   the output register, and stops early once its budget is spent; the recentre sweep
//   copies one cell per cycle between two bitmap banks; both are bound by the single read
//   port of the bitmap.
// Reset:
//   synchronous, active low. Afterwards a clearing pass zeroes the bitmap, one entry per
//   cycle, before the first tick item is taken; load_rate resets to 4 and the window low
//   corner to minus half the grid side.
// Stalls:
//   a result sits in the output register until taken; the walk holds while it waits.
`timescale 1ns / 1ps
`include "tile_window_residency_map_core_macros.svh"

module tile_window_residency_map_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  twr_pkg::t_twr_in           i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output twr_pkg::t_twr_out          o_out_data,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [twr_pkg::RATE_W-1:0] i_cfg_data
);

    import twr_pkg::*;

    t_twr_cmd w_cmd;
    t_twr_sts w_sts;
    logic     w_flags_ok;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;

    // tick sequencing
    twr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // bitmap, walker, shifter and output register
    twr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // a result item is either a creation or the closing summary
    assign w_flags_ok = o_out_data.last ^ o_out_data.is_creation;

    // checks
    `TWR_ASSERT_SAME(a_load_when_free, i_clk, i_rst_n, w_cmd.out_load, w_sts.out_free, "overrun")
    `TWR_ASSERT_SAME(a_idle_no_result, i_clk, i_rst_n, o_in_ready, !w_cmd.out_load, "idle load")
    `TWR_ASSERT_NEXT(a_one_tick, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "overlap")
    `TWR_ASSERT_SAME(a_last_is_summary, i_clk, i_rst_n, o_out_valid, w_flags_ok, "flag mismatch")

endmodule
